FILE: design/nested_region_time_accumulator_top_defines.svh
// assertion macros for the region time accumulator
`ifndef NESTED_REGION_TIME_ACCUMULATOR_TOP_DEFINES_SVH
`define NESTED_REGION_TIME_ACCUMULATOR_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define NRTA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define NRTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/nrta_pkg.sv
// ----------------------------------------------------------------------------
// nrta_pkg
// types and status codes shared by the region time accumulator
// ----------------------------------------------------------------------------
package nrta_pkg;

    localparam int IdW   = 32;
    localparam int TsW   = 48;
    localparam int StatW = 3;

    typedef enum logic [1:0] {
        CMD_ENTER = 2'd0,
        CMD_EXIT  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [StatW-1:0] {
        ST_OK          = 3'd0,
        ST_DISABLED    = 3'd1,
        ST_TABLE_FULL  = 3'd2,
        ST_STACK_FULL  = 3'd3,
        ST_STACK_EMPTY = 3'd4,
        ST_RUNNING     = 3'd5,
        ST_UNKNOWN     = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]     cmd;
        logic [IdW-1:0] region_id;
        logic [TsW-1:0] timestamp;
    } event_t;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [TsW-1:0]   total_time;
        logic             running;
        logic             timing_changed;
    } result_t;

endpackage

FILE: design/nrta_stream_if.sv
// ----------------------------------------------------------------------------
// nrta_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface nrta_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/nrta_ram.sv
// ----------------------------------------------------------------------------
// nrta_ram
// single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module nrta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/nested_region_time_accumulator_top.sv
// event path: event register on accept, stack ram read in S_READ, table update and result in S_EXEC
// a new event is taken only in S_IDLE, once the last one has done its stack ram read and table update
// the result register frees the engine, so the next event is taken while a result waits
// reset clears the stack to the sentinel, the table valid and running flags,
// and sets enable_reg; no clearing pass is needed
// ----------------------------------------------------------------------------
// nested_region_time_accumulator_top
// per-region execution time profiler with a nesting stack and a region table
// ----------------------------------------------------------------------------
`include "nested_region_time_accumulator_top_defines.svh"

module nested_region_time_accumulator_top #(
    parameter int STACK_DEPTH   = 32,
    parameter int TABLE_ENTRIES = 16,
    parameter int TIME_WIDTH    = 48
) (
    input  logic clk,
    input  logic rst_n,
    nrta_stream_if.sink   in_evt,
    nrta_stream_if.sink   cfg,
    nrta_stream_if.source out_res
);
    import nrta_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int TEW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic            enable_reg;
    logic [SCW-1:0]  count_reg;
    logic [IdW-1:0]  top_reg;
    event_t          evt_reg;
    logic            res_valid_reg;
    result_t         res_reg;

    logic [IdW-1:0]        ids_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] run_reg;
    logic [TIME_WIDTH-1:0] tot_reg [TABLE_ENTRIES];
    logic [TIME_WIDTH-1:0] start_reg [TABLE_ENTRIES];

    // stack ram
    logic           st_we;
    logic [SAW-1:0] st_waddr, st_raddr;
    logic [IdW-1:0] st_rdata;

    nrta_ram #(.WIDTH(IdW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (evt_reg.region_id),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    wire out_free = !res_valid_reg || out_res.ready;
    assign in_evt.ready  = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign out_res.valid = res_valid_reg;
    assign out_res.data  = res_reg;

    wire accept = in_evt.valid && in_evt.ready;

    // entry below top, read during S_READ; slot 0 is never written
    assign st_raddr = (count_reg >= SCW'(2)) ? SAW'(count_reg - SCW'(2)) : '0;

    // sentinel id 0 sits below the first pushed id
    wire [IdW-1:0] below_id = (count_reg == SCW'(2)) ? '0 : st_rdata;

    // table lookup
    logic            hit, has_free;
    logic [TEW-1:0]  hit_idx, free_idx;
    always_comb
    begin
        hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && ids_reg[i] == evt_reg.region_id)
            begin
                hit = 1'b1; hit_idx = TEW'(i);
            end
            if (!valid_reg[i])
            begin
                has_free = 1'b1; free_idx = TEW'(i);
            end
        end
    end

    wire [TIME_WIDTH-1:0] now_t   = TIME_WIDTH'(evt_reg.timestamp);
    wire [TIME_WIDTH-1:0] elapsed = now_t - start_reg[hit_idx];
    wire [TIME_WIDTH:0]   sum     = {1'b0, tot_reg[hit_idx]} + {1'b0, elapsed};
    wire [TIME_WIDTH-1:0] sum_sat = sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];

    // decision in S_EXEC
    status_t        d_status;
    logic           d_changed, d_entry_ok, d_push, d_pop, d_start, d_stop;
    logic [TEW-1:0] d_idx;
    always_comb
    begin
        d_status = ST_OK; d_changed = 1'b0; d_entry_ok = 1'b0; d_idx = hit_idx;
        d_push = 1'b0; d_pop = 1'b0; d_start = 1'b0; d_stop = 1'b0;
        if (!enable_reg)
        begin
            d_status = ST_DISABLED;
        end
        else
        begin
            case (cmd_t'(evt_reg.cmd))
                CMD_ENTER:
                begin
                    if (count_reg >= SCW'(STACK_DEPTH))
                        d_status = ST_STACK_FULL;
                    else if (top_reg != evt_reg.region_id)
                    begin
                        if (!hit && !has_free)
                            d_status = ST_TABLE_FULL;
                        else if (hit && run_reg[hit_idx])
                            d_status = ST_RUNNING;
                        else
                        begin
                            d_idx = hit ? hit_idx : free_idx;
                            d_start = 1'b1; d_push = 1'b1;
                            d_changed = 1'b1; d_entry_ok = 1'b1;
                        end
                    end
                    else
                    begin
                        d_push = 1'b1; d_entry_ok = hit;
                    end
                end
                CMD_EXIT:
                begin
                    if (count_reg <= SCW'(1))
                        d_status = ST_STACK_EMPTY;
                    else if (below_id != evt_reg.region_id)
                    begin
                        if (!hit || !run_reg[hit_idx])
                            d_status = ST_UNKNOWN;
                        else
                        begin
                            d_stop = 1'b1; d_pop = 1'b1;
                            d_changed = 1'b1; d_entry_ok = 1'b1;
                        end
                    end
                    else
                    begin
                        d_pop = 1'b1; d_entry_ok = hit;
                    end
                end
                CMD_READ:
                begin
                    if (!hit)
                        d_status = ST_UNKNOWN;
                    else
                        d_entry_ok = 1'b1;
                end
                default: d_status = ST_UNKNOWN;
            endcase
        end
    end

    wire exec = (state_reg == S_EXEC) && out_free;
    assign st_we    = exec && d_push;
    assign st_waddr = SAW'(count_reg);

    logic [TIME_WIDTH-1:0] new_total;
    always_comb
    begin
        new_total = tot_reg[d_idx];
        if (d_start && !hit)
            new_total = '0;
        else if (d_stop)
            new_total = sum_sat;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_READ;
            S_READ:  state_next = S_EXEC;
            S_EXEC:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b1;
            count_reg     <= SCW'(1);
            top_reg       <= '0;
            res_valid_reg <= 1'b0;
            valid_reg     <= '0;
            run_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                enable_reg <= cfg.data;
            if (exec)
                res_valid_reg <= 1'b1;
            else if (out_res.ready)
                res_valid_reg <= 1'b0;
            if (exec)
            begin
                if (d_push)
                begin
                    count_reg <= count_reg + SCW'(1);
                    top_reg   <= evt_reg.region_id;
                end
                if (d_pop)
                begin
                    count_reg <= count_reg - SCW'(1);
                    top_reg   <= below_id;
                end
                if (d_start)
                begin
                    valid_reg[d_idx] <= 1'b1;
                    run_reg[d_idx]   <= 1'b1;
                end
                if (d_stop)
                    run_reg[d_idx] <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            evt_reg <= in_evt.data;
        if (exec)
        begin
            if (d_start)
            begin
                ids_reg[d_idx]   <= evt_reg.region_id;
                start_reg[d_idx] <= now_t;
            end
            if (d_start || d_stop)
                tot_reg[d_idx] <= new_total;
            res_reg.status         <= d_status;
            res_reg.total_time     <= d_entry_ok ? TsW'(new_total) : '0;
            res_reg.running        <= d_entry_ok ? (d_start || (run_reg[d_idx] && !d_stop))
                                                 : 1'b0;
            res_reg.timing_changed <= d_entry_ok && d_changed;
        end
    end

    `NRTA_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1,
        count_reg >= SCW'(1) && count_reg <= SCW'(STACK_DEPTH), "stack count out of range")
    `NRTA_ASSERT_IMP(a_push_pop_excl, clk, rst_n, exec, !(d_push && d_pop),
        "push and pop in one step")
    `NRTA_ASSERT_NEXT(a_exec_result, clk, rst_n, exec, res_valid_reg,
        "executed event produced no result")
    `NRTA_ASSERT_IMP(a_run_valid, clk, rst_n, 1'b1, (run_reg & ~valid_reg) == '0,
        "running entry without valid")

endmodule

FILE: test/region_time_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_time_checker
// watches the event, config and result channels, keeps its own copy of the
// region stack and table, and compares every result with the oldest expected
// ----------------------------------------------------------------------------
module region_time_checker
    import nrta_pkg::*;
#(
    parameter int STACK_DEPTH   = 32,
    parameter int TABLE_ENTRIES = 16
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    evt_valid,
    input  logic    evt_ready,
    input  event_t  evt_data,
    input  logic    cfg_valid,
    input  logic    cfg_ready,
    input  logic    cfg_data,
    input  logic    res_valid,
    input  logic    res_ready,
    input  result_t res_data,
    output int      fail_count,
    output int      pending,
    output int      events_seen,
    output int      results_seen
);

    localparam logic [TsW-1:0] TIME_MAX = '1;

    logic            enable;
    logic [IdW-1:0]  open_ids [STACK_DEPTH];
    int              depth;
    logic [IdW-1:0]  region_ids [TABLE_ENTRIES];
    bit              region_used [TABLE_ENTRIES];
    logic [TsW-1:0]  region_total [TABLE_ENTRIES];
    logic [TsW-1:0]  region_start [TABLE_ENTRIES];
    bit              region_timing [TABLE_ENTRIES];
    result_t         expected_results [$];

    function automatic int find_region(logic [IdW-1:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (region_used[i] && region_ids[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic int free_region();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!region_used[i])
                return i;
        end
        return -1;
    endfunction

    // applies one event to the shadow state and returns the result it gives
    function automatic result_t apply_event(event_t ev);
        result_t        r;
        int             e;
        bit             changed;
        logic [TsW:0]   sum;
        logic [TsW-1:0] elapsed;
        r = '0;
        r.status = ST_OK;
        e = -1;
        changed = 0;
        if (!enable)
            r.status = ST_DISABLED;
        else if (ev.cmd == CMD_ENTER)
        begin
            if (depth >= STACK_DEPTH)
                r.status = ST_STACK_FULL;
            else
            begin
                e = find_region(ev.region_id);
                if (open_ids[depth-1] != ev.region_id)
                begin
                    if (e < 0)
                    begin
                        e = free_region();
                        if (e < 0)
                            r.status = ST_TABLE_FULL;
                    end
                    else if (region_timing[e])
                        r.status = ST_RUNNING;
                    if (r.status == ST_OK)
                    begin
                        if (!region_used[e])
                        begin
                            region_used[e] = 1;
                            region_ids[e] = ev.region_id;
                            region_total[e] = '0;
                        end
                        region_start[e] = ev.timestamp;
                        region_timing[e] = 1;
                        changed = 1;
                    end
                end
                if (r.status == ST_OK)
                begin
                    open_ids[depth] = ev.region_id;
                    depth++;
                end
            end
        end
        else if (ev.cmd == CMD_EXIT)
        begin
            if (depth <= 1)
                r.status = ST_STACK_EMPTY;
            else
            begin
                e = find_region(ev.region_id);
                if (open_ids[depth-2] != ev.region_id)
                begin
                    if (e < 0 || !region_timing[e])
                        r.status = ST_UNKNOWN;
                    else
                    begin
                        // elapsed wraps with the timestamp, the total saturates
                        elapsed = ev.timestamp - region_start[e];
                        sum = {1'b0, region_total[e]} + {1'b0, elapsed};
                        region_total[e] = sum[TsW] ? TIME_MAX : sum[TsW-1:0];
                        region_start[e] = '0;
                        region_timing[e] = 0;
                        changed = 1;
                    end
                end
                if (r.status == ST_OK)
                    depth--;
            end
        end
        else if (ev.cmd == CMD_READ)
        begin
            e = find_region(ev.region_id);
            if (e < 0)
                r.status = ST_UNKNOWN;
        end
        else
            r.status = ST_UNKNOWN;
        if (r.status == ST_OK && e >= 0)
        begin
            r.total_time = region_total[e];
            r.running = region_timing[e];
            r.timing_changed = changed;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            enable = 1;
            depth = 1;
            for (int i = 0; i < STACK_DEPTH; i++)
                open_ids[i] = '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                region_ids[i] = '0;
                region_used[i] = 0;
                region_total[i] = '0;
                region_start[i] = '0;
                region_timing[i] = 0;
            end
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            events_seen = 0;
            results_seen = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", res_data, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (res_data.status !== want.status)
                        report_mismatch("status", res_data.status, want.status);
                    if (res_data.total_time !== want.total_time)
                        report_mismatch("total_time", res_data.total_time, want.total_time);
                    if (res_data.running !== want.running)
                        report_mismatch("running", res_data.running, want.running);
                    if (res_data.timing_changed !== want.timing_changed)
                        report_mismatch("timing_changed", res_data.timing_changed,
                                        want.timing_changed);
                end
            end
            if (cfg_valid && cfg_ready)
                enable = cfg_data;
            if (evt_valid && evt_ready)
            begin
                events_seen++;
                expected_results.push_back(apply_event(evt_data));
            end
            pending = expected_results.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives region enter, exit, read and unknown-command events with nesting, wrapping and
// saturating times, toggles profiling on and off, and gives the verdict
// ----------------------------------------------------------------------------
module testbench;
    import nrta_pkg::*;

    localparam int             WATCHDOG_LIMIT = 5000;
    localparam logic [TsW-1:0] TIME_MAX = '1;

    logic clk;
    logic rst_n;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   fail_count;
    int   pending;
    int   events_seen;
    int   results_seen;
    int   stall_cycles;

    logic [IdW-1:0] id_pool [18];
    logic [IdW-1:0] open_shadow [$];
    logic [TsW-1:0] now_ticks;
    int             burst_left;

    nrta_stream_if #(.T(event_t))  evt_if ();
    nrta_stream_if #(.T(logic))    cfg_if ();
    nrta_stream_if #(.T(result_t)) res_if ();

    nested_region_time_accumulator_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_evt  (evt_if.sink),
        .cfg     (cfg_if.sink),
        .out_res (res_if.source)
    );

    region_time_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .evt_valid    (evt_if.valid),
        .evt_ready    (evt_if.ready),
        .evt_data     (evt_if.data),
        .cfg_valid    (cfg_if.valid),
        .cfg_ready    (cfg_if.ready),
        .cfg_data     (cfg_if.data),
        .res_valid    (res_if.valid),
        .res_ready    (res_if.ready),
        .res_data     (res_if.data),
        .fail_count   (fail_count),
        .pending      (pending),
        .events_seen  (events_seen),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((evt_if.valid && evt_if.ready) || (cfg_if.valid && cfg_if.ready)
                || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", stall_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_event(cmd_t c, logic [IdW-1:0] id, logic [TsW-1:0] ts);
        event_t ev;
        ev.cmd = c;
        ev.region_id = id;
        ev.timestamp = ts;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            evt_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct)
                @(posedge clk);
        end
        evt_if.valid <= 1'b1;
        evt_if.data <= ev;
        @(posedge clk);
        while (!evt_if.ready)
            @(posedge clk);
    endtask

    // hold off until every expected result is back and the pipeline is empty
    task automatic wait_drained();
        evt_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_enable(logic value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [IdW-1:0] pick_id();
        if ($urandom_range(0, 99) < 3)
            return $urandom();
        return id_pool[$urandom_range(0, 17)];
    endfunction

    function automatic logic [TsW-1:0] next_time();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        if ($urandom_range(0, 99) < 2)
            now_ticks = wide[TsW-1:0];
        else
            now_ticks = now_ticks + $urandom_range(0, 40);
        if ($urandom_range(0, 99) == 0)
            return wide[TsW-1:0];
        return now_ticks;
    endfunction

    // mostly balanced enter/exit nesting, with deep dives to hit the stack limit
    task automatic random_events(int count);
        int             pick;
        logic [IdW-1:0] id;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (burst_left == 0 && $urandom_range(0, 99) == 0)
                burst_left = 34;
            if (burst_left > 0)
            begin
                burst_left--;
                id = (open_shadow.size() > 0) ? open_shadow[$] : pick_id();
                if (open_shadow.size() < 40)
                    open_shadow.push_back(id);
                send_event(CMD_ENTER, id, next_time());
            end
            else if (pick < 40)
            begin
                if (open_shadow.size() > 0 && $urandom_range(0, 99) < 25)
                    id = open_shadow[$];
                else
                    id = pick_id();
                if (open_shadow.size() < 40)
                    open_shadow.push_back(id);
                send_event(CMD_ENTER, id, next_time());
            end
            else if (pick < 80)
            begin
                if (open_shadow.size() > 0 && $urandom_range(0, 99) < 90)
                    id = open_shadow.pop_back();
                else
                    id = pick_id();
                send_event(CMD_EXIT, id, next_time());
            end
            else if (pick < 95)
                send_event(CMD_READ, pick_id(), next_time());
            else
                send_event(CMD_NONE, $urandom(), next_time());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        evt_if.valid = 1'b0;
        evt_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = 1'b0;
        res_if.ready = 1'b0;
        stall_cycles = 0;
        burst_left = 0;
        now_ticks = '0;
        tx_idle_pct = 22;
        rx_idle_pct = 82;
        foreach (id_pool[i])
            id_pool[i] = $urandom();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // error paths on an empty profiler
        send_event(CMD_READ, 32'h5, 48'd0);
        send_event(CMD_EXIT, 32'h0, 48'd1);
        send_event(CMD_NONE, 32'h7, 48'd2);
        // sentinel id nests without timing
        send_event(CMD_ENTER, 32'h0, 48'd3);
        send_event(CMD_EXIT, 32'h0, 48'd4);
        // nested same id, full-range elapsed, then saturation
        send_event(CMD_ENTER, 32'hFFFF_FFFF, 48'd0);
        send_event(CMD_ENTER, 32'hFFFF_FFFF, 48'd1);
        send_event(CMD_EXIT, 32'hFFFF_FFFF, 48'd2);
        send_event(CMD_EXIT, 32'hFFFF_FFFF, TIME_MAX);
        send_event(CMD_READ, 32'hFFFF_FFFF, 48'd3);
        send_event(CMD_ENTER, 32'hFFFF_FFFF, 48'd5);
        send_event(CMD_EXIT, 32'hFFFF_FFFF, 48'h1000);
        // already running, exit of a region never started, wrapped timestamp
        send_event(CMD_ENTER, 32'h1, TIME_MAX - 48'd5);
        send_event(CMD_ENTER, 32'h8000_0000, 48'd7);
        send_event(CMD_ENTER, 32'h1, 48'd8);
        send_event(CMD_EXIT, 32'h1234, 48'd9);
        send_event(CMD_EXIT, 32'h8000_0000, 48'd9);
        send_event(CMD_EXIT, 32'h1, 48'd10);
        send_event(CMD_READ, 32'h1, 48'd11);
        send_event(CMD_READ, 32'h8000_0000, TIME_MAX);

        random_events(700);
        wait_drained();
        random_events(100);
        write_enable(1'b0);
        random_events(80);
        write_enable(1'b1);
        tx_idle_pct = 82;
        rx_idle_pct = 22;
        random_events(600);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_events(600);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d events and %0d results: nesting, stack and table limits,",
                 events_seen, results_seen);
        $display("wrap and saturation, profiling off and on, three idle mixes");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
